[hw/rtl/xsph_pkg.sv]
package xsph_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PAIR = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Fluid phase codes that take part in the correction.
  localparam logic signed [7:0] PHASE_WATER = 8'sd1;
  localparam logic signed [7:0] PHASE_OIL   = 8'sd8;

  // Reset value of epsilon: one half in Q0.16.
  localparam logic [15:0] EPS_RESET = 16'd32768;

  // Saturation limits of a Q32.16 correction.
  localparam logic [46:0] MAG_MAX = {47{1'b1}};
  localparam logic signed [48:0] CORR_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] CORR_MIN = -49'sh0_8000_0000_0000;

  // Quotient bits produced by the divider.
  localparam int QUOT_BITS = 47;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_READ_WAIT  = 13'b0000000000010,
    S_PAIR_J     = 13'b0000000000100,
    S_PAIR_CHECK = 13'b0000000001000,
    S_MUL_A      = 13'b0000000010000,
    S_MUL_B      = 13'b0000000100000,
    S_MUL_LO     = 13'b0000001000000,
    S_MUL_HI     = 13'b0000010000000,
    S_DIV_SETUP  = 13'b0000100000000,
    S_DIV        = 13'b0001000000000,
    S_ACC        = 13'b0010000000000,
    S_WRITE_I    = 13'b0100000000000,
    S_WRITE_J    = 13'b1000000000000
  } state_t;

endpackage

[hw/rtl/xsph_ram.sv]
module xsph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/xsph_pair_velocity_correction_unit.sv]
// XSPH velocity correction over a table of PARTICLE_COUNT particles. A load
// item stores one particle and clears its correction; a read item reads the
// correction table, is loaded into an output register once that is free, and
// waits there while the output is stalled. A pair item reads both particles,
// one after the other, from the two tables and then runs, for each axis and
// for each of the two particles, three registered multiplies (the wide one in
// a low and a high half), a divide by the density sum that produces one
// quotient bit a cycle, and a saturating add. A term whose quotient saturates
// skips its divide, and a pair that fails its check goes back to idle. No
// item is taken while a pair or a read is in progress.
module xsph_pair_velocity_correction_unit #(
  parameter int PARTICLE_COUNT = 4096,
  parameter int DIMENSIONS     = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [15:0]         cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [11:0]         first_index,
  input  logic [11:0]         second_index,
  input  logic signed [31:0]  velocity_x,
  input  logic signed [31:0]  velocity_y,
  input  logic signed [31:0]  velocity_z,
  input  logic [31:0]         density,
  input  logic [31:0]         particle_mass,
  input  logic signed [7:0]   phase_type,
  input  logic [31:0]         kernel_weight,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         particle_index,
  output logic signed [47:0]  correction_x,
  output logic signed [47:0]  correction_y,
  output logic signed [47:0]  correction_z
);

  import xsph_pkg::*;

  localparam int AW  = $clog2(PARTICLE_COUNT);
  localparam int AXW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int VW  = 32 * DIMENSIONS;
  localparam int PW  = VW + 72;
  localparam int CW  = 48 * DIMENSIONS;
  localparam int QCW = $clog2(QUOT_BITS + 1);

  state_t state, state_next;

  logic [15:0] smoothing_factor;

  // Held item fields.
  logic [11:0]    idx_i, idx_j;
  logic [31:0]    weight;

  // Particle data and running corrections of a pair.
  logic signed [DIMENSIONS-1:0][31:0] vel_i, vel_j;
  logic [31:0]    mass_i, mass_j;
  logic [32:0]    dens_sum;
  logic signed [47:0] corr_i [DIMENSIONS];
  logic signed [47:0] corr_j [DIMENSIONS];
  logic [AXW-1:0] axis;
  logic           term;

  // Arithmetic registers.
  logic [31:0]    prod_a;
  logic [47:0]    prod_b;
  logic [80:0]    prod_p;
  logic [32:0]    dv_mag;
  logic           dv_neg;
  logic [32:0]    rem;
  logic [46:0]    quot;
  logic [46:0]    dbits;
  logic [QCW-1:0] qcount;
  logic           sat;

  // Output register.
  logic [11:0]    out_index;
  logic signed [2:0][47:0] out_corr;

  // Memory ports.
  logic          part_wr_en, corr_wr_en;
  logic [AW-1:0] wr_addr, corr_wr_addr, rd_addr;
  logic [PW-1:0] part_wr_data, part_rd_data;
  logic [CW-1:0] corr_wr_data, corr_rd_data;

  logic accept;
  logic first_in_range, pair_in_range, idx_i_in_range;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign first_in_range = 32'(first_index) < PARTICLE_COUNT;
  assign pair_in_range  = first_in_range && (32'(second_index) < PARTICLE_COUNT);
  assign idx_i_in_range = 32'(idx_i) < PARTICLE_COUNT;

  // Pack a loaded particle.
  logic signed [2:0][31:0] vel_all;
  logic signed [DIMENSIONS-1:0][31:0] vel_in;
  assign vel_all = {velocity_z, velocity_y, velocity_x};
  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_vel_in
    assign vel_in[d] = vel_all[d];
  end
  assign part_wr_data = {phase_type, particle_mass, density, vel_in};

  // Memory address and write selection.
  assign part_wr_en = accept && (operation == OP_LOAD) && first_in_range;
  assign wr_addr    = AW'(first_index);

  always_comb begin
    corr_wr_en   = 1'b0;
    corr_wr_addr = AW'(first_index);
    corr_wr_data = '0;
    if (part_wr_en) begin
      corr_wr_en = 1'b1;
    end else if (state == S_WRITE_I) begin
      corr_wr_en   = 1'b1;
      corr_wr_addr = AW'(idx_i);
      for (int d = 0; d < DIMENSIONS; d++) begin
        corr_wr_data[48*d +: 48] = corr_i[d];
      end
    end else if (state == S_WRITE_J) begin
      corr_wr_en   = 1'b1;
      corr_wr_addr = AW'(idx_j);
      for (int d = 0; d < DIMENSIONS; d++) begin
        corr_wr_data[48*d +: 48] = corr_j[d];
      end
    end
  end

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = AW'(first_index);
    end else if (state == S_PAIR_J) begin
      rd_addr = AW'(idx_j);
    end else begin
      rd_addr = AW'(idx_i);
    end
  end

  xsph_ram #(.WIDTH(PW), .DEPTH(PARTICLE_COUNT)) u_part_ram (
    .clk     (clk),
    .wr_en   (part_wr_en),
    .wr_addr (wr_addr),
    .wr_data (part_wr_data),
    .rd_addr (rd_addr),
    .rd_data (part_rd_data)
  );

  xsph_ram #(.WIDTH(CW), .DEPTH(PARTICLE_COUNT)) u_corr_ram (
    .clk     (clk),
    .wr_en   (corr_wr_en),
    .wr_addr (corr_wr_addr),
    .wr_data (corr_wr_data),
    .rd_addr (rd_addr),
    .rd_data (corr_rd_data)
  );

  // Fields of the particle that was read.
  logic signed [7:0] rd_phase;
  logic [31:0] rd_mass, rd_dens;
  assign rd_phase = part_rd_data[PW-1 -: 8];
  assign rd_mass  = part_rd_data[VW+32 +: 32];
  assign rd_dens  = part_rd_data[VW +: 32];

  // Corrections that were read, with unused axes as zero.
  logic [2:0][47:0] rd_corr_all;
  assign rd_corr_all = 144'(corr_rd_data);

  // Pair qualification once both particles are in.
  logic signed [7:0] phase_i;
  logic pair_ok;
  logic [32:0] dens_sum_next;
  assign dens_sum_next = {1'b0, dens_sum[31:0]} + {1'b0, rd_dens};
  assign pair_ok = (phase_i >= 0)
                && (((phase_i == PHASE_WATER) && (rd_phase == PHASE_WATER))
                 || ((phase_i == PHASE_OIL) && (rd_phase == PHASE_OIL)))
                && (dens_sum_next != '0);

  // Velocity difference of the current axis, both sides sign extended.
  logic signed [32:0] dv;
  assign dv = {vel_j[axis][31], vel_j[axis]} - {vel_i[axis][31], vel_i[axis]};

  // Multiplier terms.
  logic [47:0] mul_eps;
  logic [63:0] mul_w;
  logic [56:0] mul_lo, mul_hi;
  assign mul_eps = smoothing_factor * (term ? mass_i : mass_j);
  assign mul_w   = prod_a * weight;
  assign mul_lo  = prod_b[23:0] * dv_mag;
  assign mul_hi  = prod_b[47:24] * dv_mag;

  // One restoring divide step.
  logic [33:0] div_trial;
  logic        div_take;
  assign div_trial = {rem, dbits[46]};
  assign div_take  = div_trial >= {1'b0, dens_sum};

  // Signed term and saturating add.
  logic [46:0] mag;
  logic        term_neg;
  logic signed [48:0] acc_sum, acc_term;
  logic signed [47:0] acc_base, acc_sat;
  assign mag      = sat ? MAG_MAX : quot;
  assign term_neg = term ? !dv_neg : dv_neg;
  assign acc_base = term ? corr_j[axis] : corr_i[axis];
  assign acc_term = term_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign acc_sum  = 49'(acc_base) + acc_term;
  always_comb begin
    if (acc_sum > CORR_MAX) begin
      acc_sat = CORR_MAX[47:0];
    end else if (acc_sum < CORR_MIN) begin
      acc_sat = CORR_MIN[47:0];
    end else begin
      acc_sat = acc_sum[47:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (operation == OP_READ)) begin
          state_next = S_READ_WAIT;
        end else if (accept && (operation == OP_PAIR) && pair_in_range) begin
          state_next = S_PAIR_J;
        end
      end
      S_READ_WAIT:  if (out_free) state_next = S_IDLE;
      S_PAIR_J:     state_next = S_PAIR_CHECK;
      S_PAIR_CHECK: state_next = pair_ok ? S_MUL_A : S_IDLE;
      S_MUL_A:      state_next = S_MUL_B;
      S_MUL_B:      state_next = S_MUL_LO;
      S_MUL_LO:     state_next = S_MUL_HI;
      S_MUL_HI:     state_next = S_DIV_SETUP;
      S_DIV_SETUP: begin
        state_next = (prod_p[80:47] >= {1'b0, dens_sum}) ? S_ACC : S_DIV;
      end
      S_DIV:        if (qcount == QCW'(1)) state_next = S_ACC;
      S_ACC: begin
        if (!term) begin
          state_next = S_MUL_A;
        end else if (32'(axis) == DIMENSIONS - 1) begin
          state_next = S_WRITE_I;
        end else begin
          state_next = S_MUL_A;
        end
      end
      S_WRITE_I:    state_next = S_WRITE_J;
      S_WRITE_J:    state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      smoothing_factor <= EPS_RESET;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        smoothing_factor <= cfg_write_data;
      end
      if ((state == S_READ_WAIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx_i  <= first_index;
        idx_j  <= second_index;
        weight <= kernel_weight;
        axis   <= '0;
        term   <= 1'b0;
      end
      S_READ_WAIT: begin
        if (out_free) begin
          out_index <= idx_i;
          out_corr  <= idx_i_in_range ? rd_corr_all : '0;
        end
      end
      S_PAIR_J: begin
        vel_i    <= part_rd_data[VW-1:0];
        mass_i   <= rd_mass;
        dens_sum <= {1'b0, rd_dens};
        phase_i  <= rd_phase;
        for (int d = 0; d < DIMENSIONS; d++) begin
          corr_i[d] <= corr_rd_data[48*d +: 48];
        end
      end
      S_PAIR_CHECK: begin
        vel_j    <= part_rd_data[VW-1:0];
        mass_j   <= rd_mass;
        dens_sum <= dens_sum_next;
        for (int d = 0; d < DIMENSIONS; d++) begin
          corr_j[d] <= corr_rd_data[48*d +: 48];
        end
      end
      S_MUL_A: begin
        prod_a <= mul_eps[47:16];
        dv_neg <= dv[32];
        dv_mag <= dv[32] ? 33'(-dv) : 33'(dv);
      end
      S_MUL_B: prod_b <= mul_w[63:16];
      S_MUL_LO: prod_p <= {24'b0, mul_lo};
      S_MUL_HI: prod_p <= prod_p + {mul_hi, 24'b0};
      S_DIV_SETUP: begin
        sat    <= prod_p[80:47] >= {1'b0, dens_sum};
        rem    <= prod_p[79:47];
        dbits  <= prod_p[46:0];
        quot   <= '0;
        qcount <= QCW'(QUOT_BITS);
      end
      S_DIV: begin
        rem    <= div_take ? 33'(div_trial - {1'b0, dens_sum}) : div_trial[32:0];
        quot   <= {quot[45:0], div_take};
        dbits  <= {dbits[45:0], 1'b0};
        qcount <= qcount - QCW'(1);
      end
      S_ACC: begin
        if (term) begin
          corr_j[axis] <= acc_sat;
          axis         <= axis + AXW'(1);
        end else begin
          corr_i[axis] <= acc_sat;
        end
        term <= !term;
      end
      default: begin
      end
    endcase
  end

  assign particle_index = out_index;
  assign correction_x   = out_corr[0];
  assign correction_y   = out_corr[1];
  assign correction_z   = out_corr[2];

endmodule

[tb/xsph_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the epsilon register of the XSPH unit, keeps its
// own copy of the particle table and compares every returned correction.
module xsph_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [11:0]        first_index,
  input  logic [11:0]        second_index,
  input  logic signed [31:0] velocity_x,
  input  logic signed [31:0] velocity_y,
  input  logic signed [31:0] velocity_z,
  input  logic [31:0]        density,
  input  logic [31:0]        particle_mass,
  input  logic signed [7:0]  phase_type,
  input  logic [31:0]        kernel_weight,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [11:0]        particle_index,
  input  logic signed [47:0] correction_x,
  input  logic signed [47:0] correction_y,
  input  logic signed [47:0] correction_z,
  output int                 fail_count,
  output int                 pending_reads
);

  import xsph_pkg::*;

  typedef struct {
    logic [11:0]        index;
    logic signed [47:0] corr [3];
  } read_result_t;

  // Shadow copy of the particle table.
  logic [15:0]        eps;
  logic signed [31:0] vel_tab [4096][3];
  logic [31:0]        rho_tab [4096];
  logic [31:0]        mass_tab [4096];
  logic signed [7:0]  phase_tab [4096];
  logic signed [47:0] corr_tab [4096][3];

  read_result_t expected_reads [$];

  initial pending_reads = 0;

  // Magnitude of one term: eps*m*|dv|*w / S, truncated and saturated.
  function automatic logic [46:0] term_magnitude(logic [31:0] m, logic [31:0] w,
                                                 logic [32:0] dmag, logic [32:0] s);
    logic [63:0]  a;
    logic [63:0]  b;
    logic [127:0] q;
    a = (64'(eps) * 64'(m)) >> 16;
    b = (a * 64'(w)) >> 16;
    q = (128'(b) * 128'(dmag)) / 128'(s);
    return (q > 128'(MAG_MAX)) ? MAG_MAX : q[46:0];
  endfunction

  function automatic logic signed [47:0] add_saturated(logic signed [47:0] acc,
                                                       logic signed [48:0] t);
    logic signed [48:0] sum;
    sum = 49'(acc) + t;
    if (sum > CORR_MAX) sum = CORR_MAX;
    if (sum < CORR_MIN) sum = CORR_MIN;
    return sum[47:0];
  endfunction

  // One pair item applied to the shadow table.
  task automatic apply_xsph_pair(logic [11:0] i, logic [11:0] j, logic [31:0] w);
    logic [32:0]        s;
    logic signed [32:0] dv;
    logic [32:0]        dmag;
    logic [46:0]        mag_i;
    logic [46:0]        mag_j;
    if (phase_tab[i] < 0) return;
    if (!((phase_tab[i] == PHASE_WATER && phase_tab[j] == PHASE_WATER) ||
          (phase_tab[i] == PHASE_OIL && phase_tab[j] == PHASE_OIL))) return;
    s = 33'(rho_tab[i]) + 33'(rho_tab[j]);
    if (s == 0) return;
    for (int d = 0; d < 3; d++) begin
      dv = 33'(vel_tab[j][d]) - 33'(vel_tab[i][d]);
      dmag = (dv < 0) ? 33'(-dv) : 33'(dv);
      mag_i = term_magnitude(mass_tab[j], w, dmag, s);
      mag_j = term_magnitude(mass_tab[i], w, dmag, s);
      corr_tab[i][d] = add_saturated(corr_tab[i][d],
                                     (dv < 0) ? -49'(mag_i) : 49'(mag_i));
      corr_tab[j][d] = add_saturated(corr_tab[j][d],
                                     (dv < 0) ? 49'(mag_j) : -49'(mag_j));
    end
  endtask

  // Predict on accepted items and compare accepted results.
  always @(posedge clk) begin
    read_result_t r;
    if (rst) begin
      eps <= EPS_RESET;
      fail_count = 0;
      expected_reads.delete();
    end else begin
      if (cfg_write_enable) eps <= cfg_write_data;
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: result with no item waiting, index %0d", $time, particle_index);
          fail_count++;
        end else begin
          r = expected_reads.pop_front();
          if (particle_index !== r.index) begin
            $display("%0t: particle_index expected %0d actual %0d",
                     $time, r.index, particle_index);
            fail_count++;
          end
          if (correction_x !== r.corr[0]) begin
            $display("%0t: correction_x expected %0d actual %0d",
                     $time, r.corr[0], correction_x);
            fail_count++;
          end
          if (correction_y !== r.corr[1]) begin
            $display("%0t: correction_y expected %0d actual %0d",
                     $time, r.corr[1], correction_y);
            fail_count++;
          end
          if (correction_z !== r.corr[2]) begin
            $display("%0t: correction_z expected %0d actual %0d",
                     $time, r.corr[2], correction_z);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (operation)
          OP_LOAD: begin
            vel_tab[first_index][0] = velocity_x;
            vel_tab[first_index][1] = velocity_y;
            vel_tab[first_index][2] = velocity_z;
            rho_tab[first_index] = density;
            mass_tab[first_index] = particle_mass;
            phase_tab[first_index] = phase_type;
            for (int d = 0; d < 3; d++) corr_tab[first_index][d] = '0;
          end
          OP_PAIR: apply_xsph_pair(first_index, second_index, kernel_weight);
          OP_READ: begin
            r.index = first_index;
            for (int d = 0; d < 3; d++) r.corr[d] = corr_tab[first_index][d];
            expected_reads.push_back(r);
          end
          default: ;
        endcase
      end
    end
    pending_reads = expected_reads.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import xsph_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 400;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_NONE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_enable = 1'b0;
  logic [15:0]        cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = OP_LOAD;
  logic [11:0]        first_index = '0;
  logic [11:0]        second_index = '0;
  logic signed [31:0] velocity_x = '0;
  logic signed [31:0] velocity_y = '0;
  logic signed [31:0] velocity_z = '0;
  logic [31:0]        density = '0;
  logic [31:0]        particle_mass = '0;
  logic signed [7:0]  phase_type = '0;
  logic [31:0]        kernel_weight = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [11:0]        particle_index;
  logic signed [47:0] correction_x;
  logic signed [47:0] correction_y;
  logic signed [47:0] correction_z;

  int fail_count;
  int pending_reads;
  int idle_mode = 0;
  int idle_cycles = 0;
  logic hold_go = 1'b0;
  int hold_count = 0;
  logic loaded [4096];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xsph_pair_velocity_correction_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .first_index(first_index), .second_index(second_index),
    .velocity_x(velocity_x), .velocity_y(velocity_y), .velocity_z(velocity_z),
    .density(density), .particle_mass(particle_mass), .phase_type(phase_type),
    .kernel_weight(kernel_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .particle_index(particle_index),
    .correction_x(correction_x), .correction_y(correction_y),
    .correction_z(correction_z)
  );

  xsph_checker u_checker (.*);

  // Receiver: one long hold-off on request, otherwise stalls by idle mode.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && hold_count < 700) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        2: out_stall <= ($urandom_range(99) < 79);
        3: out_stall <= ($urandom_range(99) < 12);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one item and wait until it is taken, with sender idling first in idle modes 1 and 3.
  task automatic send_item(logic [1:0] op, logic [11:0] a, logic [11:0] b,
                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                           logic [31:0] rho, logic [31:0] m, logic [7:0] ph,
                           logic [31:0] w);
    int pct;
    pct = (idle_mode == 1) ? 79 : (idle_mode == 3) ? 12 : 0;
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    in_valid <= 1'b1;
    operation <= op;
    first_index <= a;
    second_index <= b;
    velocity_x <= vx;
    velocity_y <= vy;
    velocity_z <= vz;
    density <= rho;
    particle_mass <= m;
    phase_type <= ph;
    kernel_weight <= w;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) loaded[a] = 1'b1;
  endtask

  // Let the block go quiet, then write epsilon.
  task automatic set_epsilon(logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic logic [11:0] pick_loaded();
    logic [11:0] k;
    do k = 12'($urandom_range(15)); while (!loaded[k]);
    return k;
  endfunction

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(4000)) - 2000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(4))
      0: return 32'hFFFF_FFFF;
      1: return 32'($urandom_range(200000));
      default: return $urandom();
    endcase
  endfunction

  // One random item: loads into a small pool, and mostly pairs and reads on it.
  task automatic send_random_item();
    int r;
    logic [11:0] a;
    logic [7:0] ph;
    r = $urandom_range(99);
    if (r < 30) begin
      a = ($urandom_range(19) == 0) ? 12'($urandom()) : 12'($urandom_range(15));
      case ($urandom_range(9))
        0: ph = 8'($urandom());
        1: ph = 8'($signed(-$urandom_range(128)));
        2, 3, 4, 5: ph = PHASE_WATER;
        default: ph = PHASE_OIL;
      endcase
      send_item(OP_LOAD, a, 12'($urandom()), pick_velocity(), pick_velocity(),
                pick_velocity(), ($urandom_range(15) == 0) ? 32'd0 : pick_wide(),
                pick_wide(), ph, $urandom());
    end else if (r < 70) begin
      send_item(OP_PAIR, pick_loaded(), pick_loaded(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), 8'($urandom()), pick_wide());
    end else if (r < 95) begin
      send_item(OP_READ, pick_loaded(), 12'($urandom()), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), 8'($urandom()), $urandom());
    end else begin
      send_item(OP_NONE, 12'($urandom()), 12'($urandom()), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), 8'($urandom()), $urandom());
    end
  endtask

  initial begin
    logic [15:0] eps_steps [4];
    foreach (loaded[k]) loaded[k] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the default epsilon.
    send_item(OP_LOAD, 12'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, PHASE_WATER, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 12'd4095, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, PHASE_WATER, 32'h0);
    send_item(OP_PAIR, 12'd0, 12'd4095, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_READ, 12'd0, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_READ, 12'd4095, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    // Same particle on both sides of a pair.
    send_item(OP_PAIR, 12'd0, 12'd0, '0, '0, '0, '0, '0, '0, 32'h10000);
    // Zero density sum.
    send_item(OP_LOAD, 12'd1, 12'd0, 32'd100, 32'd0, -32'sd100, 32'd0, 32'h10000,
              PHASE_OIL, '0);
    send_item(OP_LOAD, 12'd2, 12'd0, -32'sd5000, 32'd7, 32'd9, 32'd0, 32'h20000,
              PHASE_OIL, '0);
    send_item(OP_PAIR, 12'd1, 12'd2, '0, '0, '0, '0, '0, '0, 32'h10000);
    send_item(OP_READ, 12'd1, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    // Negative type on the first particle, and mixed fluid types.
    send_item(OP_LOAD, 12'd3, 12'd0, 32'd1, 32'd2, 32'd3, 32'h10000, 32'h10000,
              8'sh80, '0);
    send_item(OP_PAIR, 12'd3, 12'd0, '0, '0, '0, '0, '0, '0, 32'h10000);
    send_item(OP_PAIR, 12'd0, 12'd1, '0, '0, '0, '0, '0, '0, 32'h10000);
    send_item(OP_LOAD, 12'd2, 12'd0, 32'h0001_8000, -32'sd65536, 32'd0, 32'h18000,
              32'h30000, PHASE_OIL, '0);
    send_item(OP_LOAD, 12'd1, 12'd0, -32'sd32768, 32'd65536, 32'd0, 32'h8000,
              32'h10000, PHASE_OIL, '0);
    send_item(OP_PAIR, 12'd1, 12'd2, '0, '0, '0, '0, '0, '0, 32'h4000);
    send_item(OP_READ, 12'd1, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_READ, 12'd2, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_READ, 12'd3, 12'd0, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_NONE, 12'hFFF, 12'hFFF, '1, '1, '1, '1, '1, '1, '1);

    // Receiver holds off while reads keep coming, so the block backs up.
    hold_go <= 1'b1;
    repeat (6) send_item(OP_READ, 12'd0, 12'd0, '0, '0, '0, '0, '0, '0, '0);

    // Sender pauses until every read has come back.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);

    // Random part over several epsilon settings and idle modes.
    eps_steps[0] = 16'hFFFF;
    eps_steps[1] = 16'd0;
    eps_steps[2] = 16'($urandom());
    eps_steps[3] = EPS_RESET;
    for (int p = 0; p < 4; p++) begin
      set_epsilon(eps_steps[p]);
      for (int mode = 0; mode < 4; mode++) begin
        idle_mode = mode;
        repeat (62) send_random_item();
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
